@@ rtl/aspc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspc_pkg: shared types and constants for the audio slot playback controller
// Holds the word formats, operation and state codes and ring helpers.
// ----------------------------------------------------------------------------
package aspc_pkg;

    localparam int SLOT_COUNT       = 3;
    localparam int SPEAKER_DEPTH    = 2;
    localparam int MAX_SLOT_SAMPLES = 4096;
    localparam int SLOT_W           = $clog2(SLOT_COUNT);

    // Operation codes.
    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_SUBMIT  = 3'd1;
    localparam logic [2:0] OP_EOS     = 3'd2;
    localparam logic [2:0] OP_CANCEL  = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;

    // Player modes.
    localparam logic [2:0] M_IDLE      = 3'd0;
    localparam logic [2:0] M_STREAMING = 3'd1;
    localparam logic [2:0] M_ENDING    = 3'd2;
    localparam logic [2:0] M_STOPPING  = 3'd3;
    localparam logic [2:0] M_DRAINED   = 3'd4;

    // Slot states.
    localparam logic [1:0] S_FREE    = 2'd0;
    localparam logic [1:0] S_FILLED  = 2'd1;
    localparam logic [1:0] S_PLAYING = 2'd2;

    // Result kinds.
    localparam logic [1:0] K_STATUS = 2'd0;
    localparam logic [1:0] K_PLAY   = 2'd1;
    localparam logic [1:0] K_STOP   = 2'd2;

    // Submit status codes.
    localparam logic [1:0] P_ACCEPTED = 2'd0;
    localparam logic [1:0] P_BUSY     = 2'd1;
    localparam logic [1:0] P_MISMATCH = 2'd2;
    localparam logic [1:0] P_NOT_OPEN = 2'd3;

    localparam logic [1:0] R_NONE      = 2'd0;
    localparam logic [1:0] R_COMPLETED = 2'd1;

    // Configuration register indexes.
    localparam logic CFG_DRAIN_TIMEOUT = 1'b0;
    localparam logic CFG_SLOT_SAMPLES  = 1'b1;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] now_ms;
        logic [31:0] format_code;
        logic        format_playable;
        logic        bus_available;
        logic [15:0] chunk_count;
        logic [1:0]  cancel_reason;
        logic [1:0]  speaker_occupied;
        logic        speaker_refuses;
    } t_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  slot_index;
        logic [12:0] sample_count;
        logic [1:0]  push_status;
        logic [12:0] accepted_count;
        logic        success;
        logic [2:0]  player_state;
        logic [1:0]  end_reason;
        logic [15:0] underrun_count;
        logic [15:0] drain_timeout_count;
        logic [15:0] format_reject_count;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP,
        ST_RETIRE,
        ST_PLAY,
        ST_FINISH,
        ST_STATUS
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic retire;
        logic play;
        logic finish;
        logic status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic tick_go;
        logic retire_pend;
        logic play_ok;
    } t_stat;

    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] i);
        logic [SLOT_W-1:0] r;
        if (32'(i) + 1 >= SLOT_COUNT) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

@@ rtl/aspc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspc_ctrl: sequencer for one event
// Operation and status phases; a tick adds slot retire, play issue and finish.
// ----------------------------------------------------------------------------
module aspc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  aspc_pkg::t_stat i_stat,
    output aspc_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    aspc_pkg::t_state r_state;
    aspc_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aspc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aspc_pkg::ST_IDLE: begin
                if (i_start) n_state = aspc_pkg::ST_OP;
            end
            aspc_pkg::ST_OP: begin
                n_state = i_stat.tick_go ? aspc_pkg::ST_RETIRE : aspc_pkg::ST_STATUS;
            end
            aspc_pkg::ST_RETIRE: begin
                if (!i_stat.retire_pend) n_state = aspc_pkg::ST_PLAY;
            end
            aspc_pkg::ST_PLAY: begin
                if (!i_stat.play_ok) n_state = aspc_pkg::ST_FINISH;
            end
            aspc_pkg::ST_FINISH: n_state = aspc_pkg::ST_STATUS;
            aspc_pkg::ST_STATUS: n_state = aspc_pkg::ST_IDLE;
            default: n_state = aspc_pkg::ST_IDLE;
        endcase
    end

    // Commands.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            aspc_pkg::ST_IDLE:   o_cmd.load   = i_start;
            aspc_pkg::ST_OP:     o_cmd.exec   = 1'b1;
            aspc_pkg::ST_RETIRE: o_cmd.retire = 1'b1;
            aspc_pkg::ST_PLAY:   o_cmd.play   = 1'b1;
            aspc_pkg::ST_FINISH: o_cmd.finish = 1'b1;
            aspc_pkg::ST_STATUS: o_cmd.status = 1'b1;
            default:             o_cmd        = '0;
        endcase
    end

    assign o_busy = (r_state != aspc_pkg::ST_IDLE);

endmodule

@@ rtl/aspc_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aspc_dp: slot ring, stream state and result word register
// Carries out each phase that the controller commands.
// ----------------------------------------------------------------------------
module aspc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aspc_pkg::t_cmd    i_cmd,
    input  aspc_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output aspc_pkg::t_stat   o_stat,
    output aspc_pkg::t_result o_result,
    output logic              o_valid
);

    localparam int SW = aspc_pkg::SLOT_W;

    aspc_pkg::t_item r_item;
    logic [31:0] r_timeout;
    logic [12:0] r_slot_samples;

    logic [2:0]  r_mode;
    logic [1:0]  r_reason;
    logic [1:0]  r_sstat [aspc_pkg::SLOT_COUNT];
    logic [12:0] r_sfill [aspc_pkg::SLOT_COUNT];
    logic [SW-1:0] r_fill_ptr, r_play_ptr, r_done_ptr;
    logic [SW:0] r_waiting, r_playing;
    logic [31:0] r_format;
    logic        r_first_played, r_dry;
    logic [31:0] r_drain_start, r_last_drain;
    logic        r_drain_running;
    logic [15:0] r_under, r_tmo, r_rej;
    logic [2:0]  r_occ;
    logic [1:0]  r_push;
    logic [12:0] r_acc;
    logic        r_succ;
    aspc_pkg::t_result r_out;
    logic        r_out_valid;

    logic [12:0] cap;
    logic [12:0] take;
    logic [31:0] ds;
    logic        dry;

    // Slot capacity and the accepted part of a chunk.
    always_comb begin
        cap  = (r_slot_samples > 13'(aspc_pkg::MAX_SLOT_SAMPLES))
             ? 13'(aspc_pkg::MAX_SLOT_SAMPLES) : r_slot_samples;
        take = (r_item.chunk_count < {3'b0, cap}) ? r_item.chunk_count[12:0] : cap;
        ds   = r_drain_running ? r_drain_start : r_item.now_ms;
        dry  = (r_waiting == '0) && (r_playing == '0);
    end

    // Status to the controller.
    always_comb begin
        o_stat.tick_go     = (r_item.operation == aspc_pkg::OP_TICK)
                           && (r_mode != aspc_pkg::M_IDLE) && (r_mode != aspc_pkg::M_DRAINED);
        o_stat.retire_pend = ({1'b0, r_playing} > r_occ);
        o_stat.play_ok     = ((r_mode == aspc_pkg::M_STREAMING) || (r_mode == aspc_pkg::M_ENDING))
                           && (r_waiting != '0)
                           && (r_occ < 3'(aspc_pkg::SPEAKER_DEPTH))
                           && !r_item.speaker_refuses;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout      <= 32'd2000;
            r_slot_samples <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aspc_pkg::CFG_DRAIN_TIMEOUT: r_timeout      <= i_cfg_data;
                aspc_pkg::CFG_SLOT_SAMPLES:  r_slot_samples <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Input word capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
    end

    // Stream state and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= aspc_pkg::M_IDLE;
            r_reason        <= aspc_pkg::R_NONE;
            for (int i = 0; i < aspc_pkg::SLOT_COUNT; i++) begin
                r_sstat[i] <= aspc_pkg::S_FREE;
                r_sfill[i] <= '0;
            end
            r_fill_ptr      <= '0;
            r_play_ptr      <= '0;
            r_done_ptr      <= '0;
            r_waiting       <= '0;
            r_playing       <= '0;
            r_format        <= '0;
            r_first_played  <= 1'b0;
            r_dry           <= 1'b0;
            r_drain_start   <= '0;
            r_drain_running <= 1'b0;
            r_last_drain    <= '0;
            r_under         <= '0;
            r_tmo           <= '0;
            r_rej           <= '0;
            r_occ           <= '0;
            r_push          <= '0;
            r_acc           <= '0;
            r_succ          <= 1'b0;
            r_out           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;

            // Non-tick operations, and the occupancy snapshot for a tick.
            if (i_cmd.exec) begin
                r_push <= aspc_pkg::P_ACCEPTED;
                r_acc  <= '0;
                r_succ <= 1'b0;
                r_occ  <= {1'b0, r_item.speaker_occupied};
                case (r_item.operation)
                    aspc_pkg::OP_OPEN: begin
                        if (r_mode == aspc_pkg::M_IDLE) begin
                            r_under <= '0;
                            r_tmo   <= '0;
                            r_rej   <= '0;
                            if (!r_item.format_playable) begin
                                r_rej <= 16'd1;
                            end else if (cap != '0 && r_item.bus_available) begin
                                for (int i = 0; i < aspc_pkg::SLOT_COUNT; i++) begin
                                    r_sstat[i] <= aspc_pkg::S_FREE;
                                    r_sfill[i] <= '0;
                                end
                                r_fill_ptr      <= '0;
                                r_play_ptr      <= '0;
                                r_done_ptr      <= '0;
                                r_waiting       <= '0;
                                r_playing       <= '0;
                                r_format        <= r_item.format_code;
                                r_reason        <= aspc_pkg::R_NONE;
                                r_first_played  <= 1'b0;
                                r_dry           <= 1'b0;
                                r_drain_running <= 1'b0;
                                r_last_drain    <= '0;
                                r_mode          <= aspc_pkg::M_STREAMING;
                                r_succ          <= 1'b1;
                            end
                        end
                    end
                    aspc_pkg::OP_SUBMIT: begin
                        if (r_mode != aspc_pkg::M_STREAMING) begin
                            r_push <= aspc_pkg::P_NOT_OPEN;
                        end else if (r_item.format_code != r_format) begin
                            r_rej  <= aspc_pkg::sat_inc(r_rej);
                            r_push <= aspc_pkg::P_MISMATCH;
                        end else if (r_item.chunk_count != '0) begin
                            if (r_sstat[r_fill_ptr] != aspc_pkg::S_FREE) begin
                                r_push <= aspc_pkg::P_BUSY;
                            end else begin
                                r_sfill[r_fill_ptr] <= take;
                                r_sstat[r_fill_ptr] <= aspc_pkg::S_FILLED;
                                r_fill_ptr          <= aspc_pkg::ring_next(r_fill_ptr);
                                r_waiting           <= r_waiting + 1'b1;
                                r_acc               <= take;
                            end
                        end
                    end
                    aspc_pkg::OP_EOS: begin
                        if (r_mode == aspc_pkg::M_STREAMING) begin
                            r_mode          <= aspc_pkg::M_ENDING;
                            r_drain_running <= 1'b0;
                        end
                    end
                    aspc_pkg::OP_CANCEL: begin
                        if (r_mode == aspc_pkg::M_STREAMING || r_mode == aspc_pkg::M_ENDING) begin
                            for (int i = 0; i < aspc_pkg::SLOT_COUNT; i++) begin
                                if (r_sstat[i] == aspc_pkg::S_FILLED) begin
                                    r_sstat[i] <= aspc_pkg::S_FREE;
                                end
                            end
                            r_waiting       <= '0;
                            r_fill_ptr      <= r_play_ptr;
                            r_reason        <= r_item.cancel_reason;
                            r_mode          <= aspc_pkg::M_STOPPING;
                            r_drain_start   <= r_item.now_ms;
                            r_drain_running <= 1'b1;
                            r_out             <= '0;
                            r_out.result_kind <= aspc_pkg::K_STOP;
                            r_out_valid       <= 1'b1;
                        end
                    end
                    aspc_pkg::OP_RELEASE: begin
                        if (r_mode == aspc_pkg::M_DRAINED) begin
                            r_mode <= aspc_pkg::M_IDLE;
                            r_succ <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // Retire one finished slot.
            if (i_cmd.retire && o_stat.retire_pend) begin
                r_sstat[r_done_ptr] <= aspc_pkg::S_FREE;
                r_done_ptr          <= aspc_pkg::ring_next(r_done_ptr);
                r_playing           <= r_playing - 1'b1;
            end

            // Issue one play command.
            if (i_cmd.play && o_stat.play_ok) begin
                r_out              <= '0;
                r_out.result_kind  <= aspc_pkg::K_PLAY;
                r_out.slot_index   <= 2'(r_play_ptr);
                r_out.sample_count <= r_sfill[r_play_ptr];
                r_out_valid        <= 1'b1;
                r_sstat[r_play_ptr] <= aspc_pkg::S_PLAYING;
                r_play_ptr          <= aspc_pkg::ring_next(r_play_ptr);
                r_waiting           <= r_waiting - 1'b1;
                r_playing           <= r_playing + 1'b1;
                r_occ               <= r_occ + 3'd1;
                r_first_played      <= 1'b1;
            end

            // Underrun, drain and stop handling at the end of a tick.
            if (i_cmd.finish) begin
                if (r_mode == aspc_pkg::M_STREAMING && r_first_played) begin
                    if (dry && !r_dry) r_under <= aspc_pkg::sat_inc(r_under);
                    r_dry <= dry;
                end
                if (r_mode == aspc_pkg::M_ENDING && r_waiting == '0) begin
                    r_drain_start   <= ds;
                    r_drain_running <= 1'b1;
                    if (r_playing == '0 && r_occ == '0) begin
                        r_reason <= aspc_pkg::R_COMPLETED;
                        for (int i = 0; i < aspc_pkg::SLOT_COUNT; i++) begin
                            r_sstat[i] <= aspc_pkg::S_FREE;
                        end
                        r_fill_ptr      <= '0;
                        r_play_ptr      <= '0;
                        r_done_ptr      <= '0;
                        r_waiting       <= '0;
                        r_playing       <= '0;
                        r_last_drain    <= r_item.now_ms - ds;
                        r_drain_running <= 1'b0;
                        r_mode          <= aspc_pkg::M_DRAINED;
                    end else if (r_item.now_ms - ds >= r_timeout) begin
                        r_tmo             <= aspc_pkg::sat_inc(r_tmo);
                        r_reason          <= aspc_pkg::R_COMPLETED;
                        r_mode            <= aspc_pkg::M_STOPPING;
                        r_drain_start     <= r_item.now_ms;
                        r_out             <= '0;
                        r_out.result_kind <= aspc_pkg::K_STOP;
                        r_out_valid       <= 1'b1;
                    end
                end else if (r_mode == aspc_pkg::M_STOPPING) begin
                    if (r_occ == '0 || (r_item.now_ms - r_drain_start >= r_timeout)) begin
                        if (r_occ != '0) r_tmo <= aspc_pkg::sat_inc(r_tmo);
                        for (int i = 0; i < aspc_pkg::SLOT_COUNT; i++) begin
                            r_sstat[i] <= aspc_pkg::S_FREE;
                        end
                        r_fill_ptr      <= '0;
                        r_play_ptr      <= '0;
                        r_done_ptr      <= '0;
                        r_waiting       <= '0;
                        r_playing       <= '0;
                        r_last_drain    <= r_drain_running
                                         ? r_item.now_ms - r_drain_start : 32'd0;
                        r_drain_running <= 1'b0;
                        r_mode          <= aspc_pkg::M_DRAINED;
                    end
                end
            end

            // Final status word.
            if (i_cmd.status) begin
                r_out                     <= '0;
                r_out.result_kind         <= aspc_pkg::K_STATUS;
                r_out.push_status         <= r_push;
                r_out.accepted_count      <= r_acc;
                r_out.success             <= r_succ;
                r_out.player_state        <= r_mode;
                r_out.end_reason          <= r_reason;
                r_out.underrun_count      <= r_under;
                r_out.drain_timeout_count <= r_tmo;
                r_out.format_reject_count <= r_rej;
                r_out.last                <= 1'b1;
                r_out_valid               <= 1'b1;
            end
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_out_valid;

endmodule

@@ rtl/audio_slot_playback_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_slot_playback_controller: playback control over a ring of sample slots
// Takes stream events, issues play and stop words and one status word each.
// ----------------------------------------------------------------------------
// A plain event runs the operation phase and then the status phase; a tick
// runs the retire, play and finish phases between them.
// Events are taken one at a time; a tick stays in the retire phase while a
// finished slot is pending and in the play phase while a play word can issue.
// Reset is synchronous and active low; results cannot be held off.
module audio_slot_playback_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  aspc_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output logic              o_valid,
    output aspc_pkg::t_result o_result
);

    aspc_pkg::t_cmd  cmd;
    aspc_pkg::t_stat stat;
    logic            ctrl_busy;

    // Sequencer.
    aspc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    // Slot ring and stream state.
    aspc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_stat     (stat),
        .o_result   (o_result),
        .o_valid    (o_valid)
    );

    assign busy = ctrl_busy;

endmodule
